// File: design/sha1h_pkg.sv
// Package for the SHA-1 stream hasher: types, initial hash values and round helpers.
// Used by every module of the block; it depends on nothing else.
package sha1h_pkg;

    localparam int HASH_WORDS = 5;
    localparam int BLK_WORDS  = 16;

    typedef logic [31:0] t_word;
    typedef logic [3:0]  t_pos;
    typedef logic [6:0]  t_round;
    typedef logic [2:0]  t_idx;
    typedef logic [2:0]  t_count;
    typedef logic [60:0] t_bytes;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_vars;

    localparam t_word  INIT_H0    = 32'h67452301;
    localparam t_word  INIT_H1    = 32'hefcdab89;
    localparam t_word  INIT_H2    = 32'h98badcfe;
    localparam t_word  INIT_H3    = 32'h10325476;
    localparam t_word  INIT_H4    = 32'hc3d2e1f0;
    localparam t_word  PAD_WORD   = 32'h80000000;
    localparam t_bytes BYTE_MAX   = '1;
    localparam t_round ROUND_LAST = 7'd79;
    localparam t_pos   POS_HI     = 4'd14;
    localparam t_pos   POS_LO     = 4'd15;
    localparam t_idx   IDX_LAST   = 3'd4;
    localparam t_count COUNT_FULL = 3'd4;

    function automatic t_word init_hash(input t_idx i);
        t_word v;
        case (i)
            3'd0:    v = INIT_H0;
            3'd1:    v = INIT_H1;
            3'd2:    v = INIT_H2;
            3'd3:    v = INIT_H3;
            default: v = INIT_H4;
        endcase
        return v;
    endfunction

    // Keeps the leading valid bytes of a short final word and appends the marker byte; a full word passes unchanged.
    function automatic t_word pad_first(input t_word w, input t_count c);
        t_word v;
        case (c)
            3'd0:    v = PAD_WORD;
            3'd1:    v = {w[31:24], 24'h800000};
            3'd2:    v = {w[31:16], 16'h8000};
            3'd3:    v = {w[31:8], 8'h80};
            default: v = w;
        endcase
        return v;
    endfunction

    function automatic t_word rotl1(input t_word x);
        return {x[30:0], x[31]};
    endfunction

endpackage

// File: design/sha1h_sched_cell.sv
// One cell of the message schedule chain: holds a single 32-bit word.
// Takes its neighbour's word on every shift; uses sha1h_pkg.
module sha1h_sched_cell
    import sha1h_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_shift,
    input  t_word i_word,
    output t_word o_word
);

    t_word r_word;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_word <= i_word;
        end
    end

    assign o_word = r_word;

endmodule

// File: design/sha1h_round.sv
// Single SHA-1 round: next working variables from the current ones and one schedule word.
// Uses sha1h_pkg for the variable struct.
module sha1h_round
    import sha1h_pkg::*;
(
    input  t_vars  i_vars,
    input  t_word  i_w,
    input  t_round i_round,
    output t_vars  o_vars
);

    t_word f;
    t_word k;

    always_comb begin
        if (i_round < 7'd20) begin
            f = (i_vars.b & i_vars.c) | (~i_vars.b & i_vars.d);
            k = 32'h5a827999;
        end else if (i_round < 7'd40) begin
            f = i_vars.b ^ i_vars.c ^ i_vars.d;
            k = 32'h6ed9eba1;
        end else if (i_round < 7'd60) begin
            f = (i_vars.b & i_vars.c) | (i_vars.b & i_vars.d) | (i_vars.c & i_vars.d);
            k = 32'h8f1bbcdc;
        end else begin
            f = i_vars.b ^ i_vars.c ^ i_vars.d;
            k = 32'hca62c1d6;
        end
    end

    assign o_vars.a = {i_vars.a[26:0], i_vars.a[31:27]} + f + i_vars.e + k + i_w;
    assign o_vars.b = i_vars.a;
    assign o_vars.c = {i_vars.b[1:0], i_vars.b[31:2]};
    assign o_vars.d = i_vars.c;
    assign o_vars.e = i_vars.d;

endmodule

// File: design/sha1_stream_hasher.sv
// SHA-1 stream hasher top level: word intake, padding, round sequencer and digest output.
// A non-final word is taken while collecting; a full block then runs the S_ROUND states and
// then the S_ADD state on the single shared round unit, and no word is taken until it is done.
// The last word adds the S_PAD fill plus one or two compressions, then five
// digest requests. Reset is synchronous and active low and restores the initial hash.
// Uses sha1h_pkg, sha1h_sched_cell and sha1h_round.
module sha1_stream_hasher
    import sha1h_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // data_word[31:0], byte_count[34:32], zero[39:35]
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // digest_word[31:0]
    output logic [2:0]  o_m_axis_tuser,  // word_index[2:0]
    output logic        o_m_axis_tlast
);

    typedef enum logic [2:0] {
        S_COLLECT,
        S_ROUND,
        S_ADD,
        S_PAD,
        S_OUT
    } t_state;

    t_state r_state;
    t_word  r_hash [HASH_WORDS];
    t_vars  r_vars;
    t_pos   r_pos;
    t_bytes r_bytes;
    t_round r_round;
    t_idx   r_idx;
    logic   r_padding;
    logic   r_need80;
    logic   r_hi_done;
    logic   r_len_done;

    t_word  w [BLK_WORDS];
    t_word  tail_word;
    t_word  feedback;
    t_word  in_word;
    t_word  pad_word;
    t_count count_in;
    t_count count_c;
    t_count add_count;
    logic   in_acc;
    logic   out_acc;
    logic   shift;
    logic [61:0] sum_bytes;
    t_bytes n_bytes;
    logic [63:0] len_bits;
    t_vars  round_next;

    assign count_in  = i_s_axis_tdata[34:32];
    assign count_c   = (count_in > COUNT_FULL) ? COUNT_FULL : count_in;
    assign add_count = i_s_axis_tlast ? count_c : COUNT_FULL;
    assign sum_bytes = {1'b0, r_bytes} + 62'(add_count);
    assign n_bytes   = sum_bytes[61] ? BYTE_MAX : sum_bytes[60:0];
    assign len_bits  = {r_bytes, 3'b000};

    assign in_acc  = i_s_axis_tvalid && (r_state == S_COLLECT);
    assign out_acc = i_m_axis_tready && (r_state == S_OUT);

    assign in_word = i_s_axis_tlast ? pad_first(i_s_axis_tdata[31:0], count_c)
                                    : i_s_axis_tdata[31:0];

    always_comb begin
        if (r_need80) begin
            pad_word = PAD_WORD;
        end else if (r_pos == POS_HI) begin
            pad_word = len_bits[63:32];
        end else if (r_pos == POS_LO && r_hi_done) begin
            pad_word = len_bits[31:0];
        end else begin
            pad_word = '0;
        end
    end

    assign feedback  = rotl1(w[13] ^ w[8] ^ w[2] ^ w[0]);
    assign shift     = in_acc || (r_state == S_PAD) || (r_state == S_ROUND);

    always_comb begin
        case (r_state)
            S_ROUND: tail_word = feedback;
            S_PAD:   tail_word = pad_word;
            default: tail_word = in_word;
        endcase
    end

    for (genvar gi = 0; gi < BLK_WORDS; gi++) begin : g_cell
        sha1h_sched_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (shift),
            .i_word  ((gi == BLK_WORDS - 1) ? tail_word : w[(gi + 1) % BLK_WORDS]),
            .o_word  (w[gi])
        );
    end

    sha1h_round u_round (
        .i_vars  (r_vars),
        .i_w     (w[0]),
        .i_round (r_round),
        .o_vars  (round_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_COLLECT;
            for (int i = 0; i < HASH_WORDS; i++) begin
                r_hash[i] <= init_hash(t_idx'(i));
            end
            r_vars     <= '0;
            r_pos      <= '0;
            r_bytes    <= '0;
            r_round    <= '0;
            r_idx      <= '0;
            r_padding  <= 1'b0;
            r_need80   <= 1'b0;
            r_hi_done  <= 1'b0;
            r_len_done <= 1'b0;
        end else begin
            case (r_state)
                S_COLLECT: begin
                    if (in_acc) begin
                        r_pos   <= r_pos + 4'd1;
                        r_bytes <= n_bytes;
                        if (i_s_axis_tlast) begin
                            r_padding <= 1'b1;
                            r_need80  <= (count_c == COUNT_FULL);
                        end
                        if (r_pos == POS_LO) begin
                            r_state <= S_ROUND;
                            r_round <= '0;
                            r_vars  <= '{r_hash[0], r_hash[1], r_hash[2], r_hash[3], r_hash[4]};
                        end else if (i_s_axis_tlast) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_pos    <= r_pos + 4'd1;
                    r_need80 <= 1'b0;
                    if (!r_need80 && r_pos == POS_HI) begin
                        r_hi_done <= 1'b1;
                    end
                    if (!r_need80 && r_pos == POS_LO && r_hi_done) begin
                        r_len_done <= 1'b1;
                    end
                    if (r_pos == POS_LO) begin
                        r_state <= S_ROUND;
                        r_round <= '0;
                        r_vars  <= '{r_hash[0], r_hash[1], r_hash[2], r_hash[3], r_hash[4]};
                    end
                end
                S_ROUND: begin
                    r_vars  <= round_next;
                    r_round <= r_round + 7'd1;
                    if (r_round == ROUND_LAST) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_hash[0] <= r_hash[0] + r_vars.a;
                    r_hash[1] <= r_hash[1] + r_vars.b;
                    r_hash[2] <= r_hash[2] + r_vars.c;
                    r_hash[3] <= r_hash[3] + r_vars.d;
                    r_hash[4] <= r_hash[4] + r_vars.e;
                    r_idx     <= '0;
                    if (r_len_done) begin
                        r_state <= S_OUT;
                    end else if (r_padding) begin
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_COLLECT;
                    end
                end
                S_OUT: begin
                    if (out_acc) begin
                        if (r_idx == IDX_LAST) begin
                            r_state <= S_COLLECT;
                            for (int i = 0; i < HASH_WORDS; i++) begin
                                r_hash[i] <= init_hash(t_idx'(i));
                            end
                            r_vars     <= '0;
                            r_pos      <= '0;
                            r_bytes    <= '0;
                            r_padding  <= 1'b0;
                            r_need80   <= 1'b0;
                            r_hi_done  <= 1'b0;
                            r_len_done <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_COLLECT;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_COLLECT);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = r_hash[r_idx];
    assign o_m_axis_tuser  = r_idx;
    assign o_m_axis_tlast  = (r_idx == IDX_LAST);

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("Input and output requests are open at the same time.");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_round <= ROUND_LAST))
        else $error("Round counter ran past the last round.");

    a_out_after_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_len_done && r_pos == '0))
        else $error("Digest offered before the length block was compressed.");

    a_clean_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast)
        |=> (o_s_axis_tready && r_pos == '0 && r_bytes == '0 && !r_padding))
        else $error("State not cleared after the final digest word.");
`endif

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for sha1_stream_hasher: random and directed messages go in as
// word requests, and a built-in SHA-1 predictor checks every digest request that comes out.
// Depends on sha1h_pkg and the sha1_stream_hasher top level only.
import sha1h_pkg::*;

typedef struct packed {
    t_word word;
    t_idx  idx;
    logic  fin;
} t_digest;

class sha1_digest_checker;
    t_word   chain[HASH_WORDS];
    t_word   blk[BLK_WORDS];
    t_pos    pos;
    t_bytes  nbytes;
    t_digest digest_q[$];
    int      errors;

    function new();
        errors = 0;
        clear_state();
    endfunction

    function void clear_state();
        chain[0] = INIT_H0;
        chain[1] = INIT_H1;
        chain[2] = INIT_H2;
        chain[3] = INIT_H3;
        chain[4] = INIT_H4;
        foreach (blk[i]) blk[i] = '0;
        pos    = '0;
        nbytes = '0;
    endfunction

    function t_word rol(t_word x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function void compress();
        t_word w[80];
        t_word a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = 32'h5a827999;
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = 32'h6ed9eba1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8f1bbcdc;
            end else begin
                f = b ^ c ^ d;
                k = 32'hca62c1d6;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    function void push_word(t_word w);
        blk[pos] = w;
        pos = pos + 1'b1;
        if (pos == '0) compress();
    endfunction

    function void add_bytes(t_bytes n);
        if (nbytes > BYTE_MAX - n) nbytes = BYTE_MAX;
        else nbytes = nbytes + n;
    endfunction

    function void note_word(t_word data, t_count count, logic last);
        t_count      cnt;
        t_word       mask;
        logic [63:0] bits;
        t_digest     dg;
        cnt = (count > COUNT_FULL) ? COUNT_FULL : count;
        if (!last) begin
            push_word(data);
            add_bytes(t_bytes'(COUNT_FULL));
            return;
        end
        add_bytes(t_bytes'(cnt));
        if (cnt == COUNT_FULL) begin
            push_word(data);
            push_word(PAD_WORD);
        end else begin
            mask = (cnt == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * cnt));
            push_word((data & mask) | (32'h80 << (24 - 8 * cnt)));
        end
        while (pos != POS_HI) push_word('0);
        bits = {nbytes, 3'b000};
        push_word(bits[63:32]);
        push_word(bits[31:0]);
        for (int i = 0; i < HASH_WORDS; i++) begin
            dg.word = chain[i];
            dg.idx  = t_idx'(i);
            dg.fin  = (t_idx'(i) == IDX_LAST);
            digest_q.push_back(dg);
        end
        clear_state();
    endfunction

    function int pending();
        return digest_q.size();
    endfunction

    task report(string what);
        if (errors < 50) $display("MISMATCH at %0t: %s", $time, what);
        errors++;
    endtask

    task check_digest(t_word word, t_idx idx, logic fin);
        t_digest dg;
        if (digest_q.size() == 0) begin
            report($sformatf("unexpected digest request %h idx %0d", word, idx));
            return;
        end
        dg = digest_q.pop_front();
        if (word !== dg.word) report($sformatf("digest word %h, predicted %h", word, dg.word));
        if (idx !== dg.idx) report($sformatf("word index %0d, predicted %0d", idx, dg.idx));
        if (fin !== dg.fin) report($sformatf("last flag %b, predicted %b", fin, dg.fin));
    endtask
endclass

module tb_top;
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata  = '0;  // data_word[31:0], byte_count[34:32], zero[39:35]
    logic        i_s_axis_tlast  = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;         // digest_word[31:0]
    logic [2:0]  o_m_axis_tuser;         // word_index[2:0]
    logic        o_m_axis_tlast;

    sha1_digest_checker sb = new();

    bit steady        = 1'b0;
    bit long_hold_req = 1'b0;
    bit hold_taken    = 1'b0;
    int hold_left     = 0;
    int items_sent    = 0;

    sha1_stream_hasher u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_digest(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
        if (long_hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = 600;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (steady) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= 32);
        end
    end

    task automatic send_request(input t_word data, input t_count count, input logic last);
        while (!steady && $urandom_range(99) < 32) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {5'b0, count, data};
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_word(data, count, last);
        items_sent++;
    endtask

    task automatic send_message(input int n_words);
        t_word  data;
        t_count count;
        for (int i = 0; i < n_words; i++) begin
            case ($urandom_range(15))
                0:       data = '0;
                1:       data = '1;
                default: data = $urandom;
            endcase
            if (i == n_words - 1 || $urandom_range(3) == 0) count = t_count'($urandom_range(7));
            else count = COUNT_FULL;
            send_request(data, count, i == n_words - 1);
        end
    endtask

    initial begin
        int n_words;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty message, then one-word messages with every byte count on the last word.
        send_request('1, 3'd0, 1'b1);
        for (int c = 1; c < 8; c++)
            send_request((c % 2) ? 32'hffffffff : 32'h00000000, t_count'(c), 1'b1);
        // A short count on a word that is not last still counts as four bytes.
        send_request('0, 3'd1, 1'b0);
        send_request('1, COUNT_FULL, 1'b1);
        // Last word in slot fourteen: the length spills into a further block.
        for (int i = 0; i < 14; i++) send_request($urandom, COUNT_FULL, 1'b0);
        send_request($urandom, 3'd2, 1'b1);

        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);

        // The receiver holds off while short messages keep arriving, so the input stalls.
        long_hold_req = 1'b1;
        for (int i = 0; i < 8; i++) send_message(1);

        steady = 1'b1;
        while (items_sent < 120) send_message($urandom_range(1, 20));
        steady = 1'b0;

        while (items_sent < 360) begin
            case ($urandom_range(3))
                0:       n_words = $urandom_range(1, 4);
                1:       n_words = $urandom_range(13, 18);
                2:       n_words = $urandom_range(29, 34);
                default: n_words = $urandom_range(1, 40);
            endcase
            send_message(n_words);
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
